[rtl/apch_pkg.sv]
// Package for the aligned pair context histogram core.
// Holds the payload structs, controller command and status structs, table
// sizes, symbol constants and the symbol decoding function. No dependencies.
package apch_pkg;

  localparam int unsigned COUNT_BITS_DEF    = 32;
  localparam int unsigned POSITION_BITS_DEF = 24;

  localparam int unsigned CODES        = 7;
  localparam int unsigned PAIRS        = 49;
  localparam int unsigned SINGLE_DEPTH = 49;
  localparam int unsigned PAIR_DEPTH   = 2401;
  localparam int unsigned TRIPLE_DEPTH = 117649;

  localparam int unsigned SINGLE_AW = $clog2(SINGLE_DEPTH);
  localparam int unsigned PAIR_AW   = $clog2(PAIR_DEPTH);
  localparam int unsigned TRIPLE_AW = $clog2(TRIPLE_DEPTH);

  localparam logic [2:0] NO_CODE = 3'd7;

  localparam logic [1:0] ACT_BEGIN  = 2'd0;
  localparam logic [1:0] ACT_COLUMN = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [1:0] SEL_SINGLE = 2'd0;
  localparam logic [1:0] SEL_PAIR   = 2'd1;
  localparam logic [1:0] SEL_TRIPLE = 2'd2;

  localparam logic [7:0] SYM_T_UC = 8'h54;
  localparam logic [7:0] SYM_T_LC = 8'h74;
  localparam logic [7:0] SYM_C_UC = 8'h43;
  localparam logic [7:0] SYM_C_LC = 8'h63;
  localparam logic [7:0] SYM_A_UC = 8'h41;
  localparam logic [7:0] SYM_A_LC = 8'h61;
  localparam logic [7:0] SYM_G_UC = 8'h47;
  localparam logic [7:0] SYM_G_LC = 8'h67;
  localparam logic [7:0] SYM_N_UC = 8'h4E;
  localparam logic [7:0] SYM_N_LC = 8'h6E;
  localparam logic [7:0] SYM_DASH = 8'h2D;
  localparam logic [7:0] SYM_DOT  = 8'h2E;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  target_sym;
    logic [7:0]  query_sym;
    logic [23:0] align_start;
    logic [23:0] range_start;
    logic [23:0] range_end;
    logic [1:0]  table_select;
    logic [16:0] read_index;
  } in_t;

  typedef struct packed {
    logic [31:0] count;
    logic        index_bad;
  } out_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic exec;
    logic write;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic act_read;
    logic act_column;
  } ctrl_sts_t;

  function automatic logic [2:0] sym_code(input logic [7:0] s);
    logic [2:0] c;
    case (s) inside
      SYM_T_UC, SYM_T_LC: c = 3'd0;
      SYM_C_UC, SYM_C_LC: c = 3'd1;
      SYM_A_UC, SYM_A_LC: c = 3'd2;
      SYM_G_UC, SYM_G_LC: c = 3'd3;
      SYM_N_UC, SYM_N_LC: c = 3'd4;
      SYM_DASH:           c = 3'd5;
      SYM_DOT:            c = 3'd6;
      default:            c = NO_CODE;
    endcase
    return c;
  endfunction

endpackage

[rtl/apch_ctrl.sv]
// Controller state machine of the aligned pair context histogram core.
// Sequences the clearing pass, column updates and count reads, and owns the
// output valid flag. Depends on apch_pkg.
module apch_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  apch_pkg::ctrl_sts_t sts_i,
  output apch_pkg::ctrl_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_RESP  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.act_read) begin
          state_d = ST_RESP;
        end else if (sts_i.act_column) begin
          state_d = ST_WRITE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_to_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_EXEC))
    else $error("Accepted transaction did not move the controller to execute.");

  a_write_after_exec : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> ($past(state_q) == ST_EXEC))
    else $error("Write-back entered without a preceding execute cycle.");

  a_result_from_resp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_RESP))
    else $error("Result raised outside the response state.");

  a_clear_complete : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(state_q) == ST_CLEAR && state_q != ST_CLEAR) |-> $past(sts_i.clear_last))
    else $error("Clearing pass left before the last entry was cleared.");

endmodule

[rtl/apch_dp.sv]
// Datapath of the aligned pair context histogram core.
// Holds the transaction register, range tracking, pair history, the three
// histogram memories and the result register. Depends on apch_pkg.
module apch_dp #(
  parameter int unsigned COUNT_BITS    = apch_pkg::COUNT_BITS_DEF,
  parameter int unsigned POSITION_BITS = apch_pkg::POSITION_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  apch_pkg::in_t       in_data_i,
  input  apch_pkg::ctrl_cmd_t cmd_i,
  output apch_pkg::ctrl_sts_t sts_o,
  output apch_pkg::out_t      out_data_o
);

  localparam int unsigned SAW = apch_pkg::SINGLE_AW;
  localparam int unsigned PAW = apch_pkg::PAIR_AW;
  localparam int unsigned TAW = apch_pkg::TRIPLE_AW;

  typedef enum logic [2:0] {
    PH_SEEK  = 3'b001,
    PH_COUNT = 3'b010,
    PH_DONE  = 3'b100
  } phase_e;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  apch_pkg::in_t item_q;

  logic [POSITION_BITS-1:0] pos_q, pos_d, start_q, start_d, end_q, end_d;
  phase_e                   phase_q, phase_d;
  logic [5:0]               h1code_q, h1code_d;
  logic                     h1v_q, h1v_d, h0v_q, h0v_d;
  logic [PAW-1:0]           pp_q, pp_d;

  logic [TAW-1:0] clr_cnt_q;

  logic [2:0]     t_code, q_code;
  logic           cur_ok, is_dash, is_dot, at_start, in_range;
  logic           act_begin, act_col, act_read;
  logic           seek_step, counting, cnt_go;
  logic [5:0]     cur;
  logic [PAW-1:0] pair_idx;
  logic [TAW-1:0] trip_idx;
  logic           s_en, p_en, t_en;

  logic [COUNT_BITS-1:0] s_mem [apch_pkg::SINGLE_DEPTH];
  logic [COUNT_BITS-1:0] p_mem [apch_pkg::PAIR_DEPTH];
  logic [COUNT_BITS-1:0] t_mem [apch_pkg::TRIPLE_DEPTH];
  logic [COUNT_BITS-1:0] s_rd_q, p_rd_q, t_rd_q;
  logic [COUNT_BITS-1:0] s_wd, p_wd, t_wd;
  logic [SAW-1:0]        s_ra, s_wa, s_wa_q;
  logic [PAW-1:0]        p_ra, p_wa, p_wa_q;
  logic [TAW-1:0]        t_ra, t_wa, t_wa_q;
  logic                  s_we, p_we, t_we;
  logic                  s_en_q, p_en_q, t_en_q;

  logic [COUNT_BITS-1:0] sel_rd;
  logic [63:0]           wide;
  logic                  bad;
  apch_pkg::out_t        out_d, out_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= in_data_i;
    end
  end

  assign act_begin = (item_q.action == apch_pkg::ACT_BEGIN);
  assign act_col   = (item_q.action == apch_pkg::ACT_COLUMN);
  assign act_read  = (item_q.action == apch_pkg::ACT_READ);

  assign t_code   = apch_pkg::sym_code(item_q.target_sym);
  assign q_code   = apch_pkg::sym_code(item_q.query_sym);
  assign cur_ok   = (t_code != apch_pkg::NO_CODE) && (q_code != apch_pkg::NO_CODE);
  assign cur      = 6'(t_code) * 6'(apch_pkg::CODES) + 6'(q_code);
  assign is_dash  = (item_q.target_sym == apch_pkg::SYM_DASH);
  assign is_dot   = (item_q.target_sym == apch_pkg::SYM_DOT);
  assign at_start = (pos_q == start_q);
  assign in_range = (pos_q < end_q);

  assign seek_step = (phase_q == PH_SEEK) && !is_dash && !at_start;
  assign counting  = (phase_q == PH_COUNT) || ((phase_q == PH_SEEK) && !is_dash && at_start);
  assign cnt_go    = act_col && counting && in_range;

  assign pair_idx = PAW'(h1code_q) * PAW'(apch_pkg::PAIRS) + PAW'(cur);
  assign trip_idx = TAW'(TAW'(pp_q) * TAW'(apch_pkg::PAIRS) + TAW'(cur));

  assign s_en = cnt_go && cur_ok;
  assign p_en = s_en && h1v_q;
  assign t_en = p_en && h0v_q;

  always_comb begin
    pos_d    = pos_q;
    start_d  = start_q;
    end_d    = end_q;
    phase_d  = phase_q;
    h1code_d = h1code_q;
    h1v_d    = h1v_q;
    h0v_d    = h0v_q;
    pp_d     = pp_q;
    if (cmd_i.exec) begin
      if (act_begin) begin
        pos_d   = POSITION_BITS'(item_q.align_start);
        start_d = POSITION_BITS'(item_q.range_start);
        end_d   = POSITION_BITS'(item_q.range_end);
        phase_d = PH_SEEK;
        h1v_d   = 1'b0;
        h0v_d   = 1'b0;
      end else if (act_col) begin
        if (seek_step) begin
          pos_d = pos_q + POSITION_BITS'(1);
        end else if (counting && !in_range) begin
          phase_d = PH_DONE;
        end else if (counting) begin
          phase_d = PH_COUNT;
          if (!is_dash && !is_dot) begin
            pos_d = pos_q + POSITION_BITS'(1);
          end
          h0v_d    = h1v_q;
          pp_d     = pair_idx;
          h1code_d = cur;
          h1v_d    = cur_ok;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      start_q   <= '0;
      end_q     <= '0;
      phase_q   <= PH_DONE;
      h1v_q     <= 1'b0;
      h0v_q     <= 1'b0;
      clr_cnt_q <= '0;
      s_en_q    <= 1'b0;
      p_en_q    <= 1'b0;
      t_en_q    <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      start_q <= start_d;
      end_q   <= end_d;
      phase_q <= phase_d;
      h1v_q   <= h1v_d;
      h0v_q   <= h0v_d;
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + TAW'(1);
      end
      if (cmd_i.exec) begin
        s_en_q <= s_en;
        p_en_q <= p_en;
        t_en_q <= t_en;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    h1code_q <= h1code_d;
    pp_q     <= pp_d;
    if (cmd_i.exec) begin
      s_wa_q <= s_ra;
      p_wa_q <= p_ra;
      t_wa_q <= t_ra;
    end
  end

  assign s_ra = act_read ? item_q.read_index[SAW-1:0] : cur;
  assign p_ra = act_read ? item_q.read_index[PAW-1:0] : pair_idx;
  assign t_ra = act_read ? item_q.read_index[TAW-1:0] : trip_idx;

  assign s_we = (cmd_i.clear && clr_cnt_q < TAW'(apch_pkg::SINGLE_DEPTH)) ||
                (cmd_i.write && s_en_q);
  assign p_we = (cmd_i.clear && clr_cnt_q < TAW'(apch_pkg::PAIR_DEPTH)) ||
                (cmd_i.write && p_en_q);
  assign t_we = cmd_i.clear || (cmd_i.write && t_en_q);

  assign s_wa = cmd_i.clear ? clr_cnt_q[SAW-1:0] : s_wa_q;
  assign p_wa = cmd_i.clear ? clr_cnt_q[PAW-1:0] : p_wa_q;
  assign t_wa = cmd_i.clear ? clr_cnt_q : t_wa_q;

  assign s_wd = cmd_i.clear ? '0 : sat_inc(s_rd_q);
  assign p_wd = cmd_i.clear ? '0 : sat_inc(p_rd_q);
  assign t_wd = cmd_i.clear ? '0 : sat_inc(t_rd_q);

  always_ff @(posedge clk_i) begin
    if (s_we) begin
      s_mem[s_wa] <= s_wd;
    end
    if (cmd_i.exec) begin
      s_rd_q <= s_mem[s_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_we) begin
      p_mem[p_wa] <= p_wd;
    end
    if (cmd_i.exec) begin
      p_rd_q <= p_mem[p_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      t_mem[t_wa] <= t_wd;
    end
    if (cmd_i.exec) begin
      t_rd_q <= t_mem[t_ra];
    end
  end

  always_comb begin
    bad    = 1'b0;
    sel_rd = '0;
    case (item_q.table_select)
      apch_pkg::SEL_SINGLE: begin
        bad    = (item_q.read_index >= 17'(apch_pkg::SINGLE_DEPTH));
        sel_rd = s_rd_q;
      end
      apch_pkg::SEL_PAIR: begin
        bad    = (item_q.read_index >= 17'(apch_pkg::PAIR_DEPTH));
        sel_rd = p_rd_q;
      end
      apch_pkg::SEL_TRIPLE: begin
        bad    = (item_q.read_index >= 17'(apch_pkg::TRIPLE_DEPTH));
        sel_rd = t_rd_q;
      end
      default: begin
        bad = 1'b1;
      end
    endcase
    wide            = 64'(sel_rd);
    out_d.index_bad = bad;
    if (bad) begin
      out_d.count = '0;
    end else if (|wide[63:32]) begin
      out_d.count = '1;
    end else begin
      out_d.count = wide[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_data_o       = out_q;
  assign sts_o.clear_last = (clr_cnt_q == TAW'(apch_pkg::TRIPLE_DEPTH - 1));
  assign sts_o.act_read   = act_read;
  assign sts_o.act_column = act_col;

endmodule

[rtl/aligned_pair_context_histogram_core.sv]
// Top level of the aligned pair context histogram core.
// Joins the controller (apch_ctrl) and the datapath (apch_dp); depends on apch_pkg.
//
//   Channel  Signals                           Direction  Carries
//   in       in_valid_i, in_ready_o, in_data_i  input      begin, column or read transaction
//   out      out_valid_o, out_ready_i, out_data_o output   count read back, one per read
//
// After reset a clearing pass zeroes the histograms, one entry per cycle;
// in_ready_o stays low throughout.
// A column transaction is accepted, reads the memories in the execute state and writes back the increments.
// A begin transaction is accepted and executed; a read is accepted, executed and then waits for the result slot.
// A new transaction is accepted while an earlier result still waits on out_ready_i.
module aligned_pair_context_histogram_core #(
  parameter int unsigned COUNT_BITS    = apch_pkg::COUNT_BITS_DEF,
  parameter int unsigned POSITION_BITS = apch_pkg::POSITION_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  apch_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output apch_pkg::out_t out_data_o
);

  apch_pkg::ctrl_cmd_t cmd;
  apch_pkg::ctrl_sts_t sts;

  apch_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  apch_dp #(
    .COUNT_BITS    (COUNT_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule
